FILE: hw/rtl/texfc_pkg.sv
`default_nettype none

package texfc_pkg;

  // Source texel layouts selected by the source_format register.
  typedef enum logic [2:0] {
    FMT_RGB888   = 3'd0,
    FMT_RGBA8888 = 3'd1,
    FMT_RGBA4444 = 3'd2,
    FMT_RGBA5551 = 3'd3,
    FMT_RGB565   = 3'd4
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_OUTPUT_16BIT  = 2'd1,
    REG_FILL_WHITE    = 2'd2
  } reg_idx_e;

  localparam int unsigned TexelW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  localparam logic [TexelW-1:0] Fill32    = 32'h80FF_FFFF;
  localparam logic [TexelW-1:0] Fill16    = 32'h0000_FFFF;
  localparam logic [7:0]        AlphaOpq  = 8'h80;

endpackage

`default_nettype wire

FILE: hw/rtl/texel_format_converter.sv
`default_nettype none

// Texel format converter.
// Converts one source texel per transfer into a 32-bit ABGR texel with
// half-range alpha (0x80 = opaque) or a 16-bit 5-5-5-1 texel.
// Input: a texel is taken on a rising edge with start_i high and busy_o low.
//   busy_o stays low, so a texel may be started in every cycle.
// Output: out_valid_o is high for exactly one cycle per texel, with
//   converted_texel_o and last_texel_o; the receiver cannot stall, so
//   there is no backpressure path.
// Pipeline: input register, then one pass of select/pack logic into the
//   result register. Throughput: 1 texel per cycle, set by the single
//   conversion stage.
// Config: cfg_valid_i/cfg_ready_o write channel, cfg_index_i selects the
//   register (0 source_format, 1 output_16bit, 2 fill_white); other indexes
//   are ignored. Write only while no texel is in flight.
// Reset: pipeline valids clear; source_format = rgba8888, output_16bit = 0,
//   fill_white = 0.
module texel_format_converter (
  input  wire  logic                             clk_i,
  input  wire  logic                             rst_ni,
  input  wire  logic                             start_i,
  output logic                                   busy_o,
  input  wire  logic [texfc_pkg::TexelW-1:0]     source_texel_i,
  input  wire  logic                             end_of_image_i,
  output logic                                   out_valid_o,
  output logic [texfc_pkg::TexelW-1:0]           converted_texel_o,
  output logic                                   last_texel_o,
  input  wire  logic                             cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire  logic [texfc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  logic [texfc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import texfc_pkg::*;

  // Config registers
  fmt_e  fmt_q;
  logic  out16_q;
  logic  fill_q;

  // Input stage
  logic              in_vld_q;
  logic [TexelW-1:0] src_q;
  logic              eoi_q;

  // Result stage
  logic              res_vld_q;
  logic [TexelW-1:0] res_q, res_d;
  logic              last_q;

  // Channel views of the captured texel
  logic [7:0] b0, b1, b2, b3;
  logic [3:0] n_r, n_g, n_b, n_a;   // 4444 nibbles
  logic [4:0] f_r, f_g, f_b;        // 5-bit fields (5551 / 565)
  logic [5:0] s_g;                  // 565 green
  logic       a1;                   // 5551 alpha
  logic [TexelW-1:0] cv32, cv16;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_RGBA8888;
      out16_q <= 1'b0;
      fill_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SOURCE_FORMAT: fmt_q   <= fmt_e'(cfg_data_i);
        REG_OUTPUT_16BIT:  out16_q <= cfg_data_i[0];
        REG_FILL_WHITE:    fill_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      src_q <= source_texel_i;
      eoi_q <= end_of_image_i;
    end
    if (in_vld_q) begin
      res_q  <= res_d;
      last_q <= eoi_q;
    end
  end

  assign b0  = src_q[7:0];
  assign b1  = src_q[15:8];
  assign b2  = src_q[23:16];
  assign b3  = src_q[31:24];
  assign n_r = src_q[15:12];
  assign n_g = src_q[11:8];
  assign n_b = src_q[7:4];
  assign n_a = src_q[3:0];
  assign f_r = src_q[15:11];
  assign f_g = src_q[10:6];
  assign f_b = src_q[5:1];
  assign a1  = src_q[0];
  assign s_g = src_q[10:5];

  // 32-bit output: x*17 on a nibble is {x,x}; alpha is halved.
  always_comb begin
    case (fmt_q)
      FMT_RGB888:   cv32 = {AlphaOpq, b2, b1, b0};
      FMT_RGBA8888: cv32 = {1'b0, b3[7:1], b2, b1, b0};
      FMT_RGBA4444: cv32 = {1'b0, n_a, n_a[3:1], n_b, n_b, n_g, n_g, n_r, n_r};
      FMT_RGBA5551: cv32 = {a1, 7'd0, f_b, 3'd0, f_g, 3'd0, f_r, 3'd0};
      FMT_RGB565:   cv32 = {AlphaOpq, src_q[4:0], 3'd0, s_g, 2'd0, f_r, 3'd0};
      default:      cv32 = '0;
    endcase
  end

  // 16-bit output: {a, b5, g5, r5} in the low half.
  always_comb begin
    case (fmt_q)
      FMT_RGB888:   cv16 = {16'd0, 1'b1, b2[7:3], b1[7:3], b0[7:3]};
      FMT_RGBA8888: cv16 = {16'd0, b3[7], b2[7:3], b1[7:3], b0[7:3]};
      FMT_RGBA4444: cv16 = {16'd0, n_a[3], n_b, 1'b0, n_g, 1'b0, n_r, 1'b0};
      FMT_RGBA5551: cv16 = {16'd0, a1, f_b, f_g, f_r};
      FMT_RGB565:   cv16 = {16'd0, 1'b1, src_q[4:0], s_g[5:1], f_r};
      default:      cv16 = '0;
    endcase
  end

  always_comb begin
    if (fill_q) begin
      res_d = out16_q ? Fill16 : Fill32;
    end else begin
      res_d = out16_q ? cv16 : cv32;
    end
  end

  assign out_valid_o       = res_vld_q;
  assign converted_texel_o = res_q;
  assign last_texel_o      = last_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for the texel format converter. Texels go in through
// the start/busy command port, results come back on the out_valid strobe and
// are checked, texel and last flag, against an in-bench conversion model.
module testbench;
  import texfc_pkg::*;

  localparam int unsigned DrainCycles  = 4;       // covers the pipeline plus margin
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomPhases = 24;
  localparam int unsigned PhaseTexels  = 78;
  localparam int unsigned QuietPhases  = 4;       // final phases run back to back
  localparam logic [2:0]  FmtUnknownTop = 3'd7;   // highest undefined layout code

  typedef struct packed {
    logic [TexelW-1:0] texel;
    logic              last;
  } texel_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [TexelW-1:0]   source_texel_i;
  logic                end_of_image_i;
  logic                out_valid_o;
  logic [TexelW-1:0]   converted_texel_o;
  logic                last_texel_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  texel_format_converter uut (.*);

  // Bench copy of the register file, updated on every accepted write.
  logic [2:0] src_fmt   = FMT_RGBA8888;
  logic       out_16    = 1'b0;
  logic       fill_mode = 1'b0;

  texel_result_t pending_texels[$];
  texel_result_t head_texel;
  int unsigned   error_count  = 0;
  int unsigned   texels_seen  = 0;
  int unsigned   reg_writes   = 0;
  int unsigned   cycle_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected conversion of one source texel under the current settings.
  function automatic logic [TexelW-1:0] convert_texel(logic [TexelW-1:0] s);
    logic [15:0] p;
    logic [4:0]  r5, g5, b5;
    logic        a1;
    logic [7:0]  r8, g8, b8, a8;
    p = s[15:0];
    if (fill_mode) return out_16 ? Fill16 : Fill32;
    if (out_16) begin
      // 16-bit output: keep the top bits, alpha collapses to one bit
      a1 = 1'b1;
      case (src_fmt)
        FMT_RGB888: begin
          {b5, g5, r5} = {s[23:19], s[15:11], s[7:3]};
        end
        FMT_RGBA8888: begin
          {b5, g5, r5} = {s[23:19], s[15:11], s[7:3]};
          a1 = s[31];
        end
        FMT_RGBA4444: begin
          {r5, g5, b5} = {p[15:12], 1'b0, p[11:8], 1'b0, p[7:4], 1'b0};
          a1 = p[3];
        end
        FMT_RGBA5551: begin
          {r5, g5, b5, a1} = p;
        end
        FMT_RGB565: begin
          {r5, g5, b5} = {p[15:11], p[10:6], p[4:0]};
        end
        default: return '0;
      endcase
      return {16'h0000, a1, b5, g5, r5};
    end
    // 32-bit output: widen channels, alpha at half range
    case (src_fmt)
      FMT_RGB888:   return {AlphaOpq, s[23:0]};
      FMT_RGBA8888: return {1'b0, s[31:25], s[23:0]};
      FMT_RGBA4444: begin
        r8 = {2{p[15:12]}};
        g8 = {2{p[11:8]}};
        b8 = {2{p[7:4]}};
        a8 = {1'b0, p[3:0], p[3:1]};   // a*17 halved
      end
      FMT_RGBA5551: begin
        r8 = {p[15:11], 3'b000};
        g8 = {p[10:6], 3'b000};
        b8 = {p[5:1], 3'b000};
        a8 = {p[0], 7'b0000000};
      end
      FMT_RGB565: begin
        r8 = {p[15:11], 3'b000};
        g8 = {p[10:5], 2'b00};
        b8 = {p[4:0], 3'b000};
        a8 = AlphaOpq;
      end
      default: return '0;
    endcase
    return {a8, b8, g8, r8};
  endfunction

  task automatic report_mismatch(string what, logic [TexelW-1:0] got,
                                 logic [TexelW-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Result checker: every strobe must match the oldest pending texel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      texels_seen++;
      if (pending_texels.size() == 0) begin
        report_mismatch("unexpected texel", converted_texel_o, '0);
      end else begin
        head_texel = pending_texels.pop_front();
        if (converted_texel_o !== head_texel.texel)
          report_mismatch("converted_texel", converted_texel_o, head_texel.texel);
        if (last_texel_o !== head_texel.last)
          report_mismatch("last_texel", {31'd0, last_texel_o}, {31'd0, head_texel.last});
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d texels still pending", cycle_count,
               pending_texels.size());
      $display("status: fail");
      $finish;
    end
  end

  // Drive one texel and hold it until the transfer; start stays high so the
  // next call can follow with no bubble.
  task automatic send_texel(logic [TexelW-1:0] s, logic eoi);
    texel_result_t expect_item;
    @(negedge clk_i);
    start_i        <= 1'b1;
    source_texel_i <= s;
    end_of_image_i <= eoi;
    do @(posedge clk_i); while (busy_o);
    expect_item.texel = convert_texel(s);
    expect_item.last  = eoi;
    pending_texels.insert(pending_texels.size(), expect_item);
  endtask

  // Sender gap: start drops and the data lines carry junk meanwhile.
  task automatic idle_burst();
    int unsigned n;
    n = $urandom_range(1, 8);
    @(negedge clk_i);
    start_i        <= 1'b0;
    source_texel_i <= $urandom;
    end_of_image_i <= $urandom_range(0, 1);
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Stop sending and wait until the pipeline is empty.
  task automatic hold_until_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    hold_until_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SOURCE_FORMAT: src_fmt   = val;
      REG_OUTPUT_16BIT:  out_16    = val[0];
      REG_FILL_WHITE:    fill_mode = val[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset values: rgba8888 in, 32-bit out. Alpha halving at both ends.
  task automatic test_reset_values();
    send_texel(32'h0000_0000, 1'b0);
    send_texel(32'hFFFF_FFFF, 1'b0);
    send_texel(32'h01FF_FFFF, 1'b0);
    send_texel(32'hFE00_0000, 1'b1);
  endtask

  // 16-bit output for each known layout: upper half set with the low half
  // clear, then data set; the rgba8888 and rgba4444 probes put alpha at its top-bit edge.
  task automatic test_narrowing();
    fmt_e        fmts[5]   = '{FMT_RGB888, FMT_RGBA8888, FMT_RGBA4444,
                               FMT_RGBA5551, FMT_RGB565};
    logic [31:0] probes[5] = '{32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFF8,
                               32'h0000_FFFF, 32'h0000_FFFF};
    write_reg(REG_OUTPUT_16BIT, 3'b001);
    foreach (fmts[i]) begin
      write_reg(REG_SOURCE_FORMAT, fmts[i]);
      send_texel(32'hFFFF_0000, 1'b0);
      send_texel(probes[i], 1'b1);
    end
  endtask

  // Undefined layout codes convert to zero.
  task automatic test_unknown_format();
    write_reg(REG_SOURCE_FORMAT, FmtUnknownTop);
    send_texel(32'hFFFF_FFFF, 1'b1);
  endtask

  // Fill ignores source and layout, in both output widths.
  task automatic test_fill_white();
    write_reg(REG_FILL_WHITE, 3'b001);
    send_texel(32'h1234_5678, 1'b0);
    write_reg(REG_OUTPUT_16BIT, 3'b000);
    send_texel(32'h1234_5678, 1'b1);
    write_reg(REG_FILL_WHITE, 3'b000);
  endtask

  // Random texels over a sweep of settings. The first 16 phases walk every
  // layout code in both widths, the rest pick at random. Fill is on in some
  // phases. Idle bursts and occasional full drains until the final phases.
  task automatic test_random_stream();
    logic [31:0] corners[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                32'h8080_8080, 32'h7F7F_7F7F};
    logic [31:0] s;
    logic        eoi;
    logic        idle_on;
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      idle_on = (ph < RandomPhases - QuietPhases);
      write_reg(REG_SOURCE_FORMAT, (ph < 16) ? 3'(ph % 8) : 3'($urandom_range(0, 7)));
      write_reg(REG_OUTPUT_16BIT, (ph < 16) ? 3'(ph / 8) : 3'($urandom_range(0, 1)));
      write_reg(REG_FILL_WHITE, (ph % 6 == 5) ? 3'b001 : 3'b000);
      for (int unsigned k = 0; k < PhaseTexels; k++) begin
        if (idle_on && $urandom_range(0, 3) == 0) idle_burst();
        if (idle_on && $urandom_range(0, 59) == 0) hold_until_drained();
        s   = ($urandom_range(0, 7) == 0) ? corners[$urandom_range(0, 3)] : $urandom;
        eoi = (k == PhaseTexels - 1) || ($urandom_range(0, 15) == 0);
        send_texel(s, eoi);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    source_texel_i = '0;
    end_of_image_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_SOURCE_FORMAT;
    cfg_data_i     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_narrowing();
    test_unknown_format();
    test_fill_white();
    test_random_stream();
    hold_until_drained();

    $display("checked %0d texels across %0d register writes", texels_seen, reg_writes);
    $display("all layout codes in 32- and 16-bit output, fill mode, alpha thresholds");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
